/* hdl/rcbp_pkg.sv */
// Shared types, codes and helpers of the reference-counted buffer pool.
package rcbp_pkg;

  localparam int NUM_BUFFERS_DEF = 8;
  localparam int MAX_RINGS_DEF   = 4;

  localparam logic [2:0] OP_SELECT  = 3'd0;
  localparam logic [2:0] OP_ACQUIRE = 3'd1;
  localparam logic [2:0] OP_RELEASE = 3'd2;
  localparam logic [2:0] OP_PUSH    = 3'd3;
  localparam logic [2:0] OP_POP     = 3'd4;
  localparam logic [2:0] OP_STOP    = 3'd5;

  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_BADIDX = 3'd1;
  localparam logic [2:0] ST_UNDER  = 3'd2;
  localparam logic [2:0] ST_EMPTY  = 3'd3;
  localparam logic [2:0] ST_STOP   = 3'd4;

  localparam logic REG_BUFFERS_IN_USE = 1'b0;
  localparam logic REG_QUEUE_ENABLE   = 1'b1;

  typedef struct packed {
    logic [2:0] op;
    logic [2:0] buffer_index;
    logic [1:0] queue_id;
  } rcbp_in_t;

  typedef struct packed {
    logic [2:0] status;
    logic [2:0] index_out;
    logic       evicted;
    logic       freed;
    logic [2:0] freed_index;
    logic [3:0] delivered_mask;
    logic       ring_now_empty;
  } rcbp_out_t;

  // Reference counts stick at their ceiling rather than wrap.
  function automatic logic [7:0] count_up(input logic [7:0] c);
    count_up = (c == 8'hFF) ? c : c + 8'd1;
  endfunction

endpackage

/* hdl/rcbp_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module rcbp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hdl/refcounted_buffer_pool.sv */
// Reference-counted buffer pool with oldest-stamp eviction and consumer rings: top level.
// One word is worked on at a time and every word gives one result word. Counts and age
// stamps share one RAM and the ring contents a second; both are read one entry a cycle.
// Select sweeps the pool through the count RAM read port; push visits the four rings one
// per cycle; acquire and release read and rewrite one count, pop reads one slot, and stop,
// bad indices and empty pops go straight to the result. A result waits in the output
// register until it is taken, and the next word is accepted once it has been loaded there.
module refcounted_buffer_pool #(
  parameter int NUM_BUFFERS = rcbp_pkg::NUM_BUFFERS_DEF,
  parameter int MAX_RINGS   = rcbp_pkg::MAX_RINGS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  rcbp_pkg::rcbp_in_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output rcbp_pkg::rcbp_out_t out_data,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [3:0]          cfg_data
);
  import rcbp_pkg::*;

  // The size register is four bits wide, so no more than fifteen buffers are reachable.
  localparam int POOL_MAX = (NUM_BUFFERS < 15) ? NUM_BUFFERS : 15;
  localparam int RINGS    = (MAX_RINGS < 4) ? MAX_RINGS : 4;
  localparam int PAW      = $clog2(POOL_MAX);
  localparam int CW       = $clog2(POOL_MAX + 1);
  localparam int HW       = $clog2(POOL_MAX + 1);
  localparam int SDEPTH   = RINGS << HW;
  localparam int SAW      = (SDEPTH > 1) ? $clog2(SDEPTH) : 1;

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_SEL_WR, S_RMW, S_PUSH_RING, S_PUSH_WR, S_POP_RD, S_FIN
  } state_t;

  state_t         state;
  logic [3:0]     buffers_in_use;
  logic [3:0]     queue_enable;
  logic [3:0]     n_eff;
  logic [31:0]    stamp_counter;
  logic           stopped;
  logic [HW-1:0]  heads [4];
  logic [HW-1:0]  tails [4];
  logic [POOL_MAX-1:0] pool_valid;
  logic           pool_rv;

  logic [2:0]     cur_op;
  logic [PAW-1:0] cur_idx;
  logic [1:0]     cur_q;
  logic [7:0]     cur_cnt;
  logic [31:0]    cur_stamp;
  logic [1:0]     ring;
  rcbp_out_t      res;

  logic [CW-1:0]  scan_cnt;
  logic           rd_pend;
  logic [PAW-1:0] rd_idx;
  logic           zero_found;
  logic [PAW-1:0] zidx;
  logic [PAW-1:0] best;
  logic [31:0]    best_stamp;
  logic [7:0]     best_cnt;

  logic           pool_we;
  logic [PAW-1:0] pool_waddr;
  logic [39:0]    pool_wdata;
  logic [PAW-1:0] pool_raddr;
  logic [39:0]    pool_rdata;
  logic [7:0]     rd_cnt;
  logic [31:0]    rd_stamp;

  logic           slot_we;
  logic [SAW-1:0] slot_waddr;
  logic [SAW-1:0] slot_raddr;
  logic [2:0]     slot_rdata;

  logic           ring_on;
  logic [HW-1:0]  h_cur;
  logic [HW-1:0]  h_next;
  logic           ring_room;
  logic           q_on;
  logic [HW-1:0]  t_next;
  logic [PAW-1:0] sel_idx;
  logic [7:0]     sel_cnt;

  state_t         acc_state;
  logic [2:0]     acc_status;
  logic           acc_empty;

  assign n_eff = (buffers_in_use < 4'd4) ? 4'd4 :
                 (buffers_in_use > 4'(POOL_MAX)) ? 4'(POOL_MAX) : buffers_in_use;

  assign in_ready = (state == S_IDLE);

  // A never-written entry reads as zero count and zero stamp.
  assign rd_cnt   = pool_rv ? pool_rdata[39:32] : 8'd0;
  assign rd_stamp = pool_rv ? pool_rdata[31:0] : 32'd0;

  assign ring_on   = (32'(ring) < RINGS) && queue_enable[ring];
  assign h_cur     = heads[ring];
  assign h_next    = (CW'(h_cur) == CW'(n_eff)) ? '0 : h_cur + HW'(1);
  assign ring_room = (h_next != tails[ring]);

  assign q_on   = (32'(in_data.queue_id) < RINGS) && queue_enable[in_data.queue_id];
  assign t_next = (CW'(tails[cur_q]) == CW'(n_eff)) ? '0 : tails[cur_q] + HW'(1);

  assign sel_idx = zero_found ? zidx : best;
  assign sel_cnt = zero_found ? 8'd0 : best_cnt;

  // Outcome of an incoming word that is known before any RAM read.
  always_comb begin
    acc_state  = S_FIN;
    acc_status = ST_OK;
    acc_empty  = 1'b0;
    case (in_data.op)
      OP_SELECT: acc_state = S_SCAN;
      OP_ACQUIRE, OP_RELEASE, OP_PUSH: begin
        if ({1'b0, in_data.buffer_index} >= n_eff) begin
          acc_status = ST_BADIDX;
        end else begin
          acc_state = S_RMW;
        end
      end
      OP_POP: begin
        if (stopped) begin
          acc_status = ST_STOP;
        end else if (!q_on || heads[in_data.queue_id] == tails[in_data.queue_id]) begin
          acc_status = ST_EMPTY;
          acc_empty  = 1'b1;
        end else begin
          acc_state = S_POP_RD;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    pool_we    = 1'b0;
    pool_waddr = cur_idx;
    pool_wdata = {cur_cnt, cur_stamp};
    pool_raddr = (state == S_SCAN) ? PAW'(scan_cnt) : PAW'(in_data.buffer_index);
    case (state)
      S_SEL_WR: begin
        pool_we    = 1'b1;
        pool_waddr = sel_idx;
        pool_wdata = {count_up(sel_cnt), stamp_counter};
      end
      S_RMW: begin
        if (cur_op == OP_ACQUIRE) begin
          pool_we    = 1'b1;
          pool_wdata = {count_up(rd_cnt), rd_stamp};
        end else if (cur_op == OP_RELEASE && rd_cnt != 8'd0) begin
          pool_we    = 1'b1;
          pool_wdata = {rd_cnt - 8'd1, rd_stamp};
        end
      end
      S_PUSH_WR: pool_we = 1'b1;
      default: ;
    endcase
  end

  assign slot_we    = (state == S_PUSH_RING) && ring_on && ring_room;
  assign slot_waddr = SAW'({ring, h_cur});
  assign slot_raddr = SAW'({in_data.queue_id, tails[in_data.queue_id]});

  rcbp_ram #(.WIDTH(40), .DEPTH(POOL_MAX)) u_pool_ram (
    .clk   (clk),
    .we    (pool_we),
    .waddr (pool_waddr),
    .wdata (pool_wdata),
    .raddr (pool_raddr),
    .rdata (pool_rdata)
  );

  rcbp_ram #(.WIDTH(3), .DEPTH(SDEPTH)) u_slot_ram (
    .clk   (clk),
    .we    (slot_we),
    .waddr (slot_waddr),
    .wdata (3'(cur_idx)),
    .raddr (slot_raddr),
    .rdata (slot_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      buffers_in_use <= 4'd8;
      queue_enable   <= 4'd0;
      stamp_counter  <= 32'd1;
      stopped        <= 1'b0;
      pool_valid     <= '0;
      out_valid      <= 1'b0;
      for (int r = 0; r < 4; r++) begin
        heads[r] <= '0;
        tails[r] <= '0;
      end
    end else begin
      pool_rv <= pool_valid[pool_raddr];
      if (pool_we) begin
        pool_valid[pool_waddr] <= 1'b1;
      end
      if (out_valid && out_ready && state != S_FIN) begin
        out_valid <= 1'b0;
      end

      if (cfg_we) begin
        if (cfg_index == REG_BUFFERS_IN_USE) begin
          buffers_in_use <= cfg_data;
          for (int r = 0; r < 4; r++) begin
            heads[r] <= '0;
            tails[r] <= '0;
          end
        end else begin
          for (int r = 0; r < 4; r++) begin
            if (cfg_data[r] && !queue_enable[r]) begin
              heads[r] <= '0;
              tails[r] <= '0;
            end
          end
          queue_enable <= cfg_data;
        end
      end

      case (state)
        S_IDLE: begin
          if (in_valid) begin
            res     <= {acc_status, 3'd0, 1'b0, 1'b0, 3'd0, 4'd0, acc_empty};
            cur_op  <= in_data.op;
            cur_idx <= PAW'(in_data.buffer_index);
            cur_q   <= in_data.queue_id;
            state   <= acc_state;
            if (in_data.op == OP_SELECT) begin
              scan_cnt   <= '0;
              rd_pend    <= 1'b0;
              zero_found <= 1'b0;
            end
            if (in_data.op == OP_STOP) begin
              stopped <= 1'b1;
            end
          end
        end
        S_SCAN: begin
          if (scan_cnt < CW'(n_eff)) begin
            scan_cnt <= scan_cnt + CW'(1);
            rd_idx   <= PAW'(scan_cnt);
            rd_pend  <= 1'b1;
          end else begin
            rd_pend <= 1'b0;
            if (!rd_pend) begin
              state <= S_SEL_WR;
            end
          end
          if (rd_pend) begin
            if (!zero_found && rd_cnt == 8'd0) begin
              zero_found <= 1'b1;
              zidx       <= rd_idx;
            end
            // Strict compare keeps the lowest index among equal stamps.
            if (rd_idx == '0 || rd_stamp < best_stamp) begin
              best       <= rd_idx;
              best_stamp <= rd_stamp;
              best_cnt   <= rd_cnt;
            end
          end
        end
        S_SEL_WR: begin
          stamp_counter   <= stamp_counter + 32'd1;
          res.index_out   <= 3'(sel_idx);
          res.evicted     <= !zero_found;
          res.freed       <= !zero_found;
          res.freed_index <= zero_found ? 3'd0 : 3'(best);
          state           <= S_FIN;
        end
        S_RMW: begin
          if (cur_op == OP_PUSH && rd_cnt != 8'd0) begin
            cur_cnt       <= rd_cnt - 8'd1;
            cur_stamp     <= stamp_counter;
            stamp_counter <= stamp_counter + 32'd1;
            ring          <= 2'd0;
            state         <= S_PUSH_RING;
          end else begin
            state <= S_FIN;
          end
          if ((cur_op == OP_RELEASE || cur_op == OP_PUSH) && rd_cnt == 8'd0) begin
            res.status <= ST_UNDER;
          end else if (cur_op == OP_RELEASE && rd_cnt == 8'd1) begin
            res.freed       <= 1'b1;
            res.freed_index <= 3'(cur_idx);
          end
        end
        S_PUSH_RING: begin
          if (ring_on && ring_room) begin
            cur_cnt                  <= count_up(cur_cnt);
            heads[ring]              <= h_next;
            res.delivered_mask[ring] <= 1'b1;
          end
          ring <= ring + 2'd1;
          if (ring == 2'd3) begin
            state <= S_PUSH_WR;
          end
        end
        S_PUSH_WR: state <= S_FIN;
        S_POP_RD: begin
          res.index_out      <= slot_rdata;
          tails[cur_q]       <= t_next;
          res.ring_now_empty <= (heads[cur_q] == t_next);
          state              <= S_FIN;
        end
        S_FIN: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            out_data  <= res;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_pool_write_state: assert property (@(posedge clk) disable iff (rst)
    pool_we |-> (state == S_SEL_WR || state == S_RMW || state == S_PUSH_WR))
    else $error("count RAM written outside a write state");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second word accepted while one is in progress");

  a_head_in_range: assert property (@(posedge clk) disable iff (rst)
    (CW'(heads[0]) <= CW'(n_eff)) && (CW'(tails[0]) <= CW'(n_eff)))
    else $error("ring pointer beyond the slot count");

  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN && !out_valid) |=> (out_valid && state == S_IDLE))
    else $error("finished result not loaded into the output register");
`endif

endmodule
